@@ src/sbb_pkg.sv @@
// shared constants, types and helpers for the row box blur
package sbb_pkg;

  localparam int MAX_RADIUS_DEF   = 63;
  localparam int RING_DEPTH_DEF   = 128;
  localparam int CHANNEL_BITS_DEF = 16;

  localparam int NUM_LANES = 4;
  localparam int CNT_W     = 7;
  localparam logic [CNT_W-1:0] COUNT_MAX = 7'd127;

  localparam int RAD_W     = 6;
  localparam int RECIP_W   = 25;
  localparam int FRAC_BITS = 24;
  localparam logic [RAD_W-1:0]   RADIUS_RESET = 6'd1;
  localparam logic [RECIP_W-1:0] RECIP_RESET  = 25'd5592405;

  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  typedef enum logic [0:0] {
    REG_RADIUS,
    REG_RECIP
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_HOLD
  } ctrl_state_t;

  // tag travelling alongside each ring read
  typedef struct packed {
    logic en;
    logic first;
    logic last;
    logic use_fp;
  } rd_tag_t;

  function automatic int eff_rmax(input int max_radius, input int ring_depth);
    int half;
    half = (ring_depth - 1) / 2;
    return (max_radius < half) ? max_radius : half;
  endfunction

endpackage

@@ src/sbb_pix_in_if.sv @@
// input pixel channel
interface sbb_pix_in_if #(
  parameter int CH_W = sbb_pkg::CHANNEL_BITS_DEF
) ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;
  logic [CH_W-1:0] alpha_in;
  logic            row_end;

  modport source (
    output valid, red_in, green_in, blue_in, alpha_in, row_end,
    input  ready
  );

  modport sink (
    input  valid, red_in, green_in, blue_in, alpha_in, row_end,
    output ready
  );
endinterface

@@ src/sbb_pix_out_if.sv @@
// output pixel channel
interface sbb_pix_out_if #(
  parameter int CH_W = sbb_pkg::CHANNEL_BITS_DEF
) ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;
  logic [CH_W-1:0] alpha_out;
  logic            last_of_row;

  modport source (
    output valid, red_out, green_out, blue_out, alpha_out, last_of_row,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out, alpha_out, last_of_row,
    output ready
  );
endinterface

@@ src/sbb_ram.sv @@
// generic single-write, single-read ram with registered read data
module sbb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ src/sbb_ctrl.sv @@
// row bookkeeping and window read sequencer
module sbb_ctrl #(
  parameter int MAX_RADIUS = sbb_pkg::MAX_RADIUS_DEF,
  parameter int RING_DEPTH = sbb_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          row_end,
  input  logic [sbb_pkg::RAD_W-1:0]     radius,
  input  logic                          loaded,
  output logic                          ready,
  output logic                          first_we,
  output logic [$clog2(RING_DEPTH)-1:0] waddr,
  output logic [$clog2(RING_DEPTH)-1:0] raddr,
  output logic                          rd_en,
  output sbb_pkg::rd_tag_t              tag,
  output logic                          res_last
);
  import sbb_pkg::*;

  localparam int AW   = $clog2(RING_DEPTH);
  localparam int RMAX = eff_rmax(MAX_RADIUS, RING_DEPTH);
  localparam logic [RAD_W-1:0] RMAX_V    = RAD_W'(RMAX);
  localparam logic [AW-1:0]    SLOT_LAST = AW'(RING_DEPTH - 1);
  localparam logic [CNT_W:0]   DEPTH_V   = (CNT_W+1)'(RING_DEPTH);

  ctrl_state_t state, state_next;

  logic [CNT_W-1:0]        seen;
  logic [AW-1:0]           slot;
  logic [CNT_W-1:0]        cur_x;
  logic [AW-1:0]           cur_slot;
  logic                    cur_end;
  logic [RAD_W-1:0]        cur_r;
  logic [RAD_W-1:0]        cen;
  logic signed [CNT_W:0]   age;
  logic [CNT_W-1:0]        rem;
  logic                    first_rd;
  logic [RAD_W-1:0]        r_eff;
  logic [RAD_W-1:0]        c0;
  logic                    need_out;
  logic                    more;
  logic [CNT_W-1:0]        age_clamp;
  logic [CNT_W:0]          addr_sum;

  assign r_eff     = (radius > RMAX_V) ? RMAX_V : radius;
  assign c0        = (row_end && (seen < CNT_W'(r_eff))) ? seen[RAD_W-1:0] : r_eff;
  assign need_out  = row_end || (seen >= CNT_W'(r_eff));
  assign more      = cur_end && (cen != '0);
  assign age_clamp = age[CNT_W] ? '0 : age[CNT_W-1:0];
  assign addr_sum  = (CNT_W+1)'(cur_slot) + DEPTH_V - (CNT_W+1)'(age_clamp);
  assign raddr     = (addr_sum >= DEPTH_V) ? AW'(addr_sum - DEPTH_V) : AW'(addr_sum);
  assign waddr     = slot;
  assign first_we  = (seen == '0);
  assign res_last  = cur_end && (cen == '0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && need_out) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (rem == '0) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (loaded) begin
          state_next = more ? ST_SUM : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ready = (state == ST_IDLE);
    rd_en = (state == ST_SUM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      seen  <= '0;
      slot  <= '0;
      tag   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (row_end) begin
          seen <= '0;
          slot <= '0;
        end else begin
          seen <= (seen < COUNT_MAX) ? seen + 1'b1 : seen;
          slot <= (slot == SLOT_LAST) ? '0 : slot + 1'b1;
        end
      end
      tag <= '{en: rd_en, first: first_rd, last: (rem == '0), use_fp: (age_clamp > cur_x)};
    end
  end

  // window walk: ages from c+r down to c-r, clamped at the newest pixel
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      cur_x    <= seen;
      cur_slot <= slot;
      cur_end  <= row_end;
      cur_r    <= r_eff;
      cen      <= c0;
      age      <= (CNT_W+1)'(c0) + (CNT_W+1)'(r_eff);
      rem      <= CNT_W'({r_eff, 1'b0});
      first_rd <= 1'b1;
    end else if (state == ST_SUM) begin
      age      <= age - (CNT_W+1)'(1);
      rem      <= rem - 1'b1;
      first_rd <= 1'b0;
    end else if (state == ST_HOLD && loaded && more) begin
      cen      <= cen - 1'b1;
      age      <= (CNT_W+1)'(cen) + (CNT_W+1)'(cur_r) - (CNT_W+1)'(1);
      rem      <= CNT_W'({cur_r, 1'b0});
      first_rd <= 1'b1;
    end
  end
endmodule

@@ src/sbb_lane.sv @@
// one colour channel: window accumulate, scale, round and saturate
module sbb_lane #(
  parameter int CH_W  = sbb_pkg::CHANNEL_BITS_DEF,
  parameter int SUM_W = 23
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sbb_pkg::rd_tag_t            tag,
  input  logic [CH_W-1:0]             din,
  input  logic [sbb_pkg::RECIP_W-1:0] recip,
  input  logic                        loaded,
  output logic                        valid,
  output logic [CH_W-1:0]             res
);
  import sbb_pkg::*;

  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int Q_W    = PROD_W + 1 - FRAC_BITS;
  localparam logic [PROD_W:0] ROUND_BIAS = (PROD_W+1)'(1) << (FRAC_BITS - 1);

  logic [SUM_W-1:0]  acc;
  logic              done;
  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]   rounded;
  logic [Q_W-1:0]    q;

  always_ff @(posedge clk) begin
    if (tag.en) begin
      acc <= tag.first ? SUM_W'(din) : acc + SUM_W'(din);
    end
    if (done) begin
      prod <= PROD_W'(acc) * PROD_W'(recip);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done  <= 1'b0;
      valid <= 1'b0;
    end else begin
      done <= tag.en && tag.last;
      if (done) begin
        valid <= 1'b1;
      end else if (loaded) begin
        valid <= 1'b0;
      end
    end
  end

  assign rounded = (PROD_W+1)'(prod) + ROUND_BIAS;
  assign q       = rounded[PROD_W:FRAC_BITS];
  assign res     = (|q[Q_W-1:CH_W]) ? '1 : q[CH_W-1:0];
endmodule

@@ src/sbb_merge.sv @@
// joins the four lane results into one output beat register
module sbb_merge #(
  parameter int CH_W = sbb_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [sbb_pkg::NUM_LANES-1:0]           lane_valid,
  input  logic [sbb_pkg::NUM_LANES-1:0][CH_W-1:0] lane_res,
  input  logic                                    res_last,
  output logic                                    loaded,
  sbb_pix_out_if.source                           pix_out
);
  assign loaded = (&lane_valid) && (!pix_out.valid || pix_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (loaded) begin
      pix_out.valid <= 1'b1;
    end else if (pix_out.ready) begin
      pix_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (loaded) begin
      pix_out.red_out     <= lane_res[0];
      pix_out.green_out   <= lane_res[1];
      pix_out.blue_out    <= lane_res[2];
      pix_out.alpha_out   <= lane_res[3];
      pix_out.last_of_row <= res_last;
    end
  end
endmodule

@@ src/sliding_box_blur_row.sv @@
// top level: one-dimensional rgba box blur over a pixel row with edge clamping
// a pixel that completes no window leaves the input ready; one that does holds ready low until its outputs are loaded
// each output walks the 2r+1 window pixels through the single ring read port, one per cycle,
// then accumulates, scales and loads the output register
// a row-end pixel yields min(x,r)+1 outputs
// reset sets radius 1 and reciprocal 5592405, clears control; the ring needs no clearing
module sliding_box_blur_row #(
  parameter int MAX_RADIUS   = sbb_pkg::MAX_RADIUS_DEF,
  parameter int RING_DEPTH   = sbb_pkg::RING_DEPTH_DEF,
  parameter int CHANNEL_BITS = sbb_pkg::CHANNEL_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  sbb_pix_in_if.sink                 pix_in,
  sbb_pix_out_if.source              pix_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sbb_pkg::APB_AW-1:0] paddr,
  input  logic [sbb_pkg::APB_DW-1:0] pwdata,
  output logic [sbb_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import sbb_pkg::*;

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int PIX_W = NUM_LANES * CHANNEL_BITS;
  localparam int SUM_W = CHANNEL_BITS + $clog2(2 * eff_rmax(MAX_RADIUS, RING_DEPTH) + 1);

  logic [RAD_W-1:0]   radius;
  logic [RECIP_W-1:0] recip;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  logic               accept;
  logic [PIX_W-1:0]   in_word;
  logic [PIX_W-1:0]   first_px;
  logic [PIX_W-1:0]   ring_q;
  logic [PIX_W-1:0]   pix_d;
  logic               first_we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic               rd_en;
  rd_tag_t            tag;
  logic               res_last;
  logic               loaded;

  logic [NUM_LANES-1:0]                   lane_valid;
  logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] lane_res;

  // register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[APB_AW-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
      recip  <= RECIP_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RADIUS: radius <= pwdata[RAD_W-1:0];
        REG_RECIP:  recip  <= pwdata[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_RADIUS: prdata = APB_DW'(radius);
      REG_RECIP:  prdata = APB_DW'(recip);
      default:    prdata = '0;
    endcase
  end

  // pixel path
  assign accept  = pix_in.valid && pix_in.ready;
  assign in_word = {pix_in.alpha_in, pix_in.blue_in, pix_in.green_in, pix_in.red_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      first_px <= '0;
    end else if (accept && first_we) begin
      first_px <= in_word;
    end
  end

  sbb_ctrl #(
    .MAX_RADIUS (MAX_RADIUS),
    .RING_DEPTH (RING_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .row_end  (pix_in.row_end),
    .radius   (radius),
    .loaded   (loaded),
    .ready    (pix_in.ready),
    .first_we (first_we),
    .waddr    (waddr),
    .raddr    (raddr),
    .rd_en    (rd_en),
    .tag      (tag),
    .res_last (res_last)
  );

  sbb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (in_word),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (ring_q)
  );

  // left edge reads the first pixel of the row
  assign pix_d = tag.use_fp ? first_px : ring_q;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    sbb_lane #(
      .CH_W  (CHANNEL_BITS),
      .SUM_W (SUM_W)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .tag    (tag),
      .din    (pix_d[l*CHANNEL_BITS +: CHANNEL_BITS]),
      .recip  (recip),
      .loaded (loaded),
      .valid  (lane_valid[l]),
      .res    (lane_res[l])
    );
  end

  sbb_merge #(
    .CH_W (CHANNEL_BITS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .lane_valid (lane_valid),
    .lane_res   (lane_res),
    .res_last   (res_last),
    .loaded     (loaded),
    .pix_out    (pix_out)
  );
endmodule

@@ verif/sbb_blur_checker.sv @@
// watches the pixel and register ports, predicts every blurred pixel and compares
module sbb_blur_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [15:0]                in_red,
  input  logic [15:0]                in_green,
  input  logic [15:0]                in_blue,
  input  logic [15:0]                in_alpha,
  input  logic                       in_row_end,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [15:0]                out_red,
  input  logic [15:0]                out_green,
  input  logic [15:0]                out_blue,
  input  logic [15:0]                out_alpha,
  input  logic                       out_last,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [sbb_pkg::APB_AW-1:0] paddr,
  input  logic [sbb_pkg::APB_DW-1:0] pwdata,
  output int                         errors,
  output int                         pending,
  output int                         checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import sbb_pkg::*;

  localparam int REPORT_LIMIT = 40;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic        last;
  } blur_pix_t;

  blur_pix_t          blur_expected[$];
  logic [63:0]        row_ring [RING_DEPTH_DEF];
  logic [63:0]        row_first;
  logic [CNT_W-1:0]   row_count;
  logic [6:0]         ring_wr;
  logic [RAD_W-1:0]   radius_q;
  logic [RECIP_W-1:0] recip_q;
  int                 mismatches;
  int                 beats_checked;

  function automatic logic [15:0] scale_to_pixel(input int unsigned sum,
                                                 input logic [RECIP_W-1:0] recip);
    logic [63:0] prod;
    prod = (64'(sum) * 64'(recip) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return (prod > 64'hFFFF) ? 16'hFFFF : prod[15:0];
  endfunction

  // one pixel in: store it, then queue the window results it completes
  task automatic absorb_pixel(input logic [63:0] px, input logic row_end);
    int          eff_r;
    int          pos;
    int          first_c;
    int          last_c;
    int          age;
    int unsigned acc [4];
    logic [6:0]  slot;
    logic [63:0] tap;
    blur_pix_t   res;
    eff_r = int'(radius_q);
    if (eff_r > MAX_RADIUS_DEF) eff_r = MAX_RADIUS_DEF;
    if (eff_r > (RING_DEPTH_DEF - 1) / 2) eff_r = (RING_DEPTH_DEF - 1) / 2;
    slot = ring_wr;
    row_ring[slot] = px;
    if (row_count == '0) row_first = px;
    pos = int'(row_count);
    if (row_count < COUNT_MAX) row_count = row_count + 1'b1;
    ring_wr = slot + 7'd1;
    if (row_end) begin
      first_c = (pos < eff_r) ? pos : eff_r;
      last_c = 0;
    end else begin
      if (pos < eff_r) return;
      first_c = eff_r;
      last_c = eff_r;
    end
    for (int c = first_c; c >= last_c; c--) begin
      for (int ch = 0; ch < 4; ch++) acc[ch] = 0;
      // window offset k sits at age c - k, clamped to the newest pixel
      for (int k = -eff_r; k <= eff_r; k++) begin
        age = c - k;
        if (age < 0) age = 0;
        if (age > pos) tap = row_first;
        else tap = row_ring[slot - 7'(age)];
        for (int ch = 0; ch < 4; ch++) acc[ch] += tap[16*ch +: 16];
      end
      res.red   = scale_to_pixel(acc[0], recip_q);
      res.green = scale_to_pixel(acc[1], recip_q);
      res.blue  = scale_to_pixel(acc[2], recip_q);
      res.alpha = scale_to_pixel(acc[3], recip_q);
      res.last  = row_end && (c == 0);
      blur_expected.push_back(res);
    end
    if (row_end) begin
      row_count = '0;
      ring_wr = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: beat %0d %s expected %h got %h", $time, beats_checked, name,
                 want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    blur_pix_t want;
    if (rst) begin
      blur_expected.delete();
      row_first = '0;
      row_count = '0;
      ring_wr = '0;
      radius_q = RADIUS_RESET;
      recip_q = RECIP_RESET;
      mismatches = 0;
      beats_checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (blur_expected.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: beat with nothing expected, got %h %h %h %h last %b", $time,
                     out_red, out_green, out_blue, out_alpha, out_last);
          mismatches++;
        end else begin
          want = blur_expected.pop_front();
          check_field("red", want.red, out_red);
          check_field("green", want.green, out_green);
          check_field("blue", want.blue, out_blue);
          check_field("alpha", want.alpha, out_alpha);
          check_field("last_of_row", 16'(want.last), 16'(out_last));
          beats_checked++;
        end
      end
      if (in_valid && in_ready)
        absorb_pixel({in_alpha, in_blue, in_green, in_red}, in_row_end);
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_AW-1:2]))
          REG_RADIUS: radius_q = pwdata[RAD_W-1:0];
          REG_RECIP:  recip_q = pwdata[RECIP_W-1:0];
          default: ;
        endcase
      end
    end
    errors  <= mismatches;
    pending <= blur_expected.size();
    checked <= beats_checked;
  end

endmodule

@@ verif/tb_sliding_box_blur_row.sv @@
// testbench top: drives pixel rows and register writes into the row box blur
module tb_sliding_box_blur_row;
  timeunit 1ns;
  timeprecision 1ps;
  import sbb_pkg::*;

  localparam int ITEM_TARGET   = 230;
  localparam int SETTLE_CYCLES = 2 * MAX_RADIUS_DEF + 16;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int          blur_errors;
  int          blur_pending;
  int          blur_checked;
  int          pixels_sent = 0;
  int          rows_sent = 0;
  int          reg_writes = 0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;
  bit          src_gaps = 1'b0;
  bit          sink_stalls = 1'b0;

  sbb_pix_in_if  pix_in ();
  sbb_pix_out_if pix_out ();

  sliding_box_blur_row i_dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sbb_blur_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pix_in.valid),
    .in_ready   (pix_in.ready),
    .in_red     (pix_in.red_in),
    .in_green   (pix_in.green_in),
    .in_blue    (pix_in.blue_in),
    .in_alpha   (pix_in.alpha_in),
    .in_row_end (pix_in.row_end),
    .out_valid  (pix_out.valid),
    .out_ready  (pix_out.ready),
    .out_red    (pix_out.red_out),
    .out_green  (pix_out.green_out),
    .out_blue   (pix_out.blue_out),
    .out_alpha  (pix_out.alpha_out),
    .out_last   (pix_out.last_of_row),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .errors     (blur_errors),
    .pending    (blur_pending),
    .checked    (blur_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_sliding_box_blur_row failed");
      $finish;
    end
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 63);
    if (roll < 52) return 0;
    if (roll < 62) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // output side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      pix_out.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= 1'b1;
      if (sink_stalls) stall_left <= pick_gap();
    end
  end

  function automatic logic [31:0] recip_for(input int radius);
    return 32'(((1 << FRAC_BITS) + radius) / (2 * radius + 1));
  endfunction

  task automatic send_pixel(input logic [15:0] red, input logic [15:0] green,
                            input logic [15:0] blue, input logic [15:0] alpha,
                            input logic last);
    int gap;
    gap = src_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in.valid    <= 1'b1;
    pix_in.red_in   <= red;
    pix_in.green_in <= green;
    pix_in.blue_in  <= blue;
    pix_in.alpha_in <= alpha;
    pix_in.row_end  <= last;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    pixels_sent++;
    if (last) rows_sent++;
  endtask

  task automatic send_row(input int len);
    logic [15:0] ch [4];
    bit          extreme;
    for (int i = 0; i < len; i++) begin
      extreme = ($urandom_range(0, 7) == 0);
      for (int c = 0; c < 4; c++)
        ch[c] = extreme ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                        : 16'($urandom_range(0, 65535));
      send_pixel(ch[0], ch[1], ch[2], ch[3], i == len - 1);
    end
  endtask

  // wait for every expected beat, then let the block finish any window in flight
  task automatic quiesce();
    pix_in.valid <= 1'b0;
    do @(posedge clk); while (blur_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(int'(idx) * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic set_blur(input logic [31:0] radius_word, input logic [31:0] recip_word);
    quiesce();
    apb_write(REG_RADIUS, radius_word);
    apb_write(REG_RECIP, recip_word);
  endtask

  initial begin
    int          radius;
    int          len;
    logic [31:0] recip;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    pix_in.valid    <= 1'b0;
    pix_in.red_in   <= '0;
    pix_in.green_in <= '0;
    pix_in.blue_in  <= '0;
    pix_in.alpha_in <= '0;
    pix_in.row_end  <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: radius 1, single-pixel row then short rows
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_pixel(16'hAAAA, 16'h5555, 16'h0001, 16'h8000, 1'b0);
    send_pixel(16'h5555, 16'hAAAA, 16'h8000, 16'h0001, 1'b0);
    send_pixel(16'hFFFF, 16'h0000, 16'h7FFF, 16'hFFFE, 1'b1);

    // no blur, unity scale
    set_blur(32'd0, 32'd16777216);
    send_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    send_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    send_pixel(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE, 1'b1);

    // widest window, smallest scale
    set_blur(32'd63, 32'd132104);
    send_pixel(16'hFFFF, 16'hFFFF, 16'h0000, 16'h1234, 1'b0);
    send_pixel(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFEDC, 1'b0);
    send_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000, 1'b0);
    send_pixel(16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b1);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);

    // oversized scale saturates; upper data bits carry junk
    set_blur(32'hFFFF_FFC2, 32'hFFFF_FFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 16'h4000, 1'b0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);

    // radius shrinks part way through a row
    set_blur(32'd3, recip_for(3));
    send_pixel(16'h1111, 16'h2222, 16'h3333, 16'h4444, 1'b0);
    send_pixel(16'hEEEE, 16'hDDDD, 16'hCCCC, 16'hBBBB, 1'b0);
    quiesce();
    apb_write(REG_RADIUS, 32'd1);
    send_pixel(16'h0F0F, 16'hF0F0, 16'hFFFF, 16'h0000, 1'b0);
    send_pixel(16'h7777, 16'h8888, 16'h9999, 16'h6666, 1'b0);
    send_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b1);

    // long row: count saturates and the ring wraps
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    radius = $urandom_range(1, 63);
    set_blur(32'(radius), recip_for(radius));
    send_row($urandom_range(130, 140));

    while (pixels_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 5))
        0:       radius = 0;
        1:       radius = 1;
        2:       radius = $urandom_range(2, 4);
        3:       radius = MAX_RADIUS_DEF;
        default: radius = $urandom_range(0, 63);
      endcase
      case ($urandom_range(0, 7))
        0:       recip = $urandom_range(132104, 16777216);
        1:       recip = $urandom & 32'h01FF_FFFF;
        2:       recip = 32'd16777216;
        default: recip = recip_for(radius);
      endcase
      src_gaps = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      set_blur(32'(radius), recip);
      repeat ($urandom_range(1, 3)) begin
        len = $urandom_range(1, (radius < 8) ? 2 * radius + 4 : 10);
        send_row(len);
      end
    end

    quiesce();
    $display("covered %0d pixels in %0d rows over %0d register writes", pixels_sent,
             rows_sent, reg_writes);
    $display("radii 0 to 63, unity, minimum and oversized scales, %0d beats checked",
             blur_checked);
    if (blur_errors == 0) begin
      $display("tb_sliding_box_blur_row passed");
    end else begin
      $display("tb_sliding_box_blur_row failed");
    end
    $finish;
  end

endmodule
